// ----- hdl/oart_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// open-addressed record table. No dependencies.
package oart_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int NUM_SLOTS   = 2048;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int REC_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = 11;
  localparam int ATT_W       = SLOT_W + 1;
  localparam int NAME_W      = 128;
  localparam int META_W      = 128;
  localparam int IN_W        = 256;
  localparam int OUT_W       = 152;
  localparam int PADDR_W     = 3;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_PUT    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  typedef struct packed {
    logic load;        // capture the accepted word, start at the home slot
    logic clear_start; // zero counts, restart the sweep address
    logic sweep;       // write one empty slot and step the sweep address
    logic advance;     // move to the next probe position
    logic mark_empty;  // chain ended on an empty slot
    logic mark_hit;    // live record with the name found
    logic mark_none;   // probe bound reached
    logic commit;      // apply the operation
    logic out_load;    // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic slot_empty;
    logic rec_match;
    logic last_attempt;
    logic clr_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/open_addressed_record_table_top.sv -----
// Top level of the open-addressed record table: configuration register,
// controller and datapath. Uses oart_pkg, oart_ctrl and oart_dp.
//
// Usage. Operations arrive on the slave stream: s_tuser carries the mode
// (search, put, remove, clear) and s_tdata the name and metadata. Each word
// yields exactly one result word on the master stream with the found flag,
// the found metadata, the space left, the status and the live count.
// The capacity register sits at APB byte address 0 and must only be written
// while the block is idle.
//
// Sequencing. One operation is in flight at a time. Each probe of the slot
// chain is a slot memory read, a record memory read and a name compare. A
// clear sweeps all 2048 slots before its result is put out.
//
// Reset. After rst the same sweep of all 2048 slots empties the slot table;
// s_tready stays low until it finishes. Configuration writes are taken at any time.
//
// Stalls. The result sits in an output register. While the receiver holds
// m_tready low, the next word is still accepted and processed; it then waits
// in the controller until the output register frees up.
module open_addressed_record_table_top (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oart_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // name_hi[63:0], name_lo[127:64], meta_hi[191:128], meta_lo[255:192]
  input  logic [oart_pkg::IN_W-1:0]     s_tdata,
  // mode[1:0]
  input  logic [1:0]                    s_tuser,
  // Master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // found[0], found_meta_hi[64:1], found_meta_lo[128:65], space_left[139:129],
  // status[140], live_count[151:141]
  output logic [oart_pkg::OUT_W-1:0]    m_tdata
);
  import oart_pkg::*;

  logic [CNT_W-1:0] capacity;
  cmd_t             cmd;
  sts_t             sts;

  // The capacity register. Writes complete in the APB access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(MAX_RECORDS);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  oart_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .in_mode(s_tuser),
    .sts(sts), .s_tready(s_tready), .cmd(cmd)
  );

  oart_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .capacity(capacity), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .sts(sts)
  );

endmodule

// ----- hdl/oart_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module oart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/oart_ctrl.sv -----
// Controller state machine of the record table: sequences the clearing
// sweep, the probe loop, the commit and the result hand-off. Uses oart_pkg.
module oart_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic [1:0]    in_mode,
  input  oart_pkg::sts_t sts,
  output logic          s_tready,
  output oart_pkg::cmd_t cmd
);
  import oart_pkg::*;

  localparam logic [2:0] ST_CLR       = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_SLOT_WAIT = 3'd2;
  localparam logic [2:0] ST_SLOT_CHK  = 3'd3;
  localparam logic [2:0] ST_REC_CHK   = 3'd4;
  localparam logic [2:0] ST_COMMIT    = 3'd5;
  localparam logic [2:0] ST_FIN       = 3'd6;

  logic [2:0] state, state_next;
  logic       reply, reply_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd        = '0;
    unique case (state)
      ST_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.clr_done) begin
          state_next = reply ? ST_FIN : ST_IDLE;
          reply_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_mode == MODE_CLEAR) begin
            cmd.clear_start = 1'b1;
            reply_next      = 1'b1;
            state_next      = ST_CLR;
          end else begin
            state_next = ST_SLOT_WAIT;
          end
        end
      end
      ST_SLOT_WAIT: state_next = ST_SLOT_CHK;
      ST_SLOT_CHK: begin
        if (sts.slot_empty) begin
          cmd.mark_empty = 1'b1;
          state_next     = ST_COMMIT;
        end else begin
          state_next = ST_REC_CHK;
        end
      end
      ST_REC_CHK: begin
        if (sts.rec_match) begin
          cmd.mark_hit = 1'b1;
          state_next   = ST_COMMIT;
        end else if (sts.last_attempt) begin
          cmd.mark_none = 1'b1;
          state_next    = ST_COMMIT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_SLOT_WAIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

endmodule

// ----- hdl/oart_dp.sv -----
// Datapath of the record table: slot and record memories, probe position,
// counts, result and output registers. Uses oart_pkg and oart_ram.
module oart_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  oart_pkg::cmd_t                cmd,
  input  logic [1:0]                    s_tuser,
  input  logic [oart_pkg::IN_W-1:0]     s_tdata,
  input  logic [oart_pkg::CNT_W-1:0]    capacity,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [oart_pkg::OUT_W-1:0]    m_tdata,
  output oart_pkg::sts_t                sts
);
  import oart_pkg::*;

  logic [1:0]        mode;
  logic [NAME_W-1:0] name;
  logic [META_W-1:0] meta;
  logic [SLOT_W-1:0] pos, empty_slot, clr_addr;
  logic [ATT_W-1:0]  attempt;
  logic [CNT_W-1:0]  appended, deleted;
  logic              hit, has_empty;
  logic              res_found, res_status;
  logic [META_W-1:0] res_meta;

  logic [SLOT_W-1:0] slot_rdata, slot_waddr, slot_wdata;
  logic              slot_we;
  logic [REC_W-1:0]  rec_raddr, rec_waddr;
  logic [NAME_W-1:0] name_rdata;
  logic [META_W-1:0] meta_rdata;
  logic              flag_rdata, flag_wdata, flag_we, name_we, meta_we;
  logic [CNT_W-1:0]  eff_cap, space, live;
  logic              full, do_append;

  // Record numbers start at 1; the stores are indexed from 0.
  assign rec_raddr = REC_W'(slot_rdata - SLOT_W'(1));
  assign eff_cap   = (capacity > CNT_W'(MAX_RECORDS)) ? CNT_W'(MAX_RECORDS) : capacity;
  assign full      = (appended >= eff_cap);
  assign space     = full ? '0 : CNT_W'(eff_cap - appended);
  assign live      = CNT_W'(appended - deleted);
  assign do_append = cmd.commit && (mode == MODE_PUT) && !hit && !full && has_empty;

  always_comb begin
    slot_we    = cmd.sweep || do_append;
    slot_waddr = cmd.sweep ? clr_addr : empty_slot;
    slot_wdata = cmd.sweep ? '0 : SLOT_W'(appended + CNT_W'(1));
    rec_waddr  = do_append ? REC_W'(appended) : rec_raddr;
    name_we    = do_append;
    meta_we    = do_append || (cmd.commit && mode == MODE_PUT && hit);
    flag_we    = do_append || (cmd.commit && mode == MODE_REMOVE && hit);
    flag_wdata = !do_append;
  end

  oart_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(pos), .rdata(slot_rdata)
  );
  oart_ram #(.WIDTH(NAME_W), .DEPTH(MAX_RECORDS)) u_name (
    .clk(clk), .we(name_we), .waddr(rec_waddr), .wdata(name),
    .raddr(rec_raddr), .rdata(name_rdata)
  );
  oart_ram #(.WIDTH(META_W), .DEPTH(MAX_RECORDS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(rec_waddr), .wdata(meta),
    .raddr(rec_raddr), .rdata(meta_rdata)
  );
  oart_ram #(.WIDTH(1), .DEPTH(MAX_RECORDS)) u_flag (
    .clk(clk), .we(flag_we), .waddr(rec_waddr), .wdata(flag_wdata),
    .raddr(rec_raddr), .rdata(flag_rdata)
  );

  assign sts.slot_empty   = (slot_rdata == '0);
  assign sts.rec_match    = (name_rdata == name) && !flag_rdata;
  assign sts.last_attempt = (attempt == ATT_W'(NUM_SLOTS));
  assign sts.clr_done     = (clr_addr == SLOT_W'(NUM_SLOTS - 1));
  assign sts.out_busy     = m_tvalid && !m_tready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      appended <= '0;
      deleted  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear_start) begin
        clr_addr <= '0;
        appended <= '0;
        deleted  <= '0;
      end else begin
        if (cmd.sweep) begin
          clr_addr <= clr_addr + SLOT_W'(1);
        end
        if (do_append) begin
          appended <= appended + CNT_W'(1);
        end
        if (cmd.commit && mode == MODE_REMOVE && hit) begin
          deleted <= deleted + CNT_W'(1);
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode       <= s_tuser;
      name       <= s_tdata[127:0];
      meta       <= s_tdata[255:128];
      pos        <= s_tdata[64 +: SLOT_W];
      attempt    <= ATT_W'(1);
      res_found  <= 1'b0;
      res_status <= 1'b0;
      res_meta   <= '0;
    end
    if (cmd.advance) begin
      pos     <= pos + SLOT_W'(attempt);
      attempt <= attempt + ATT_W'(1);
    end
    if (cmd.mark_empty) begin
      hit        <= 1'b0;
      has_empty  <= 1'b1;
      empty_slot <= pos;
    end
    if (cmd.mark_hit) begin
      hit       <= 1'b1;
      has_empty <= 1'b0;
    end
    if (cmd.mark_none) begin
      hit       <= 1'b0;
      has_empty <= 1'b0;
    end
    if (cmd.commit) begin
      res_found <= hit;
      if (mode == MODE_SEARCH && hit) begin
        res_meta <= meta_rdata;
      end
      if (mode == MODE_PUT && !hit && (full || !has_empty)) begin
        res_status <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      // res_meta holds meta_lo above meta_hi, as it came in on s_tdata.
      m_tdata <= {live, res_status, space, res_meta[127:64], res_meta[63:0], res_found};
    end
  end

endmodule

// ----- hdl/oart_checker.sv -----
// Port-level checker for the record table, bound to the top level.
// Uses oart_pkg.
module oart_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [oart_pkg::OUT_W-1:0] m_tdata
);
  import oart_pkg::*;

  // A result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before it was taken");

  // Reset starts the clearing sweep, so no word is taken right after it.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("word accepted during the reset sweep");

  // One operation at a time: an accept is never followed by another at once.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");

  // An overflow only happens for a name that was not found.
  a_overflow_new: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[140] |-> !m_tdata[0])
    else $error("overflow reported for an existing name");

endmodule

bind open_addressed_record_table_top oart_checker u_oart_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
